// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the look-at view matrix block.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define LAV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define LAV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lav_pkg.sv =====
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
// No dependencies.
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int VEC_W         = 3 * WORD_W;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int SAT_W         = PROD_W + 4;
    localparam int SQRT_STEPS    = WORD_W;
    localparam int IDX_W         = 4;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

    typedef logic signed [WORD_W-1:0] lav_word_t;
    typedef lav_word_t [2:0] lav_vec_t;

    typedef struct packed {
        lav_word_t eye_x;
        lav_word_t eye_y;
        lav_word_t eye_z;
        lav_word_t target_x;
        lav_word_t target_y;
        lav_word_t target_z;
    } lav_cam_t;

    typedef struct packed {
        logic [IDX_W-1:0] element_index;
        lav_word_t        element_value;
        logic             last_element;
    } lav_elem_t;

    // finished matrix: side, true up, negated forward, translation
    typedef struct packed {
        lav_vec_t  s;
        lav_vec_t  u;
        lav_vec_t  nf;
        lav_word_t tx;
        lav_word_t ty;
        lav_word_t tz;
    } lav_mat_t;

    localparam logic signed [SAT_W-1:0] WORD_MAX = {{(SAT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] WORD_MIN = {{(SAT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    function automatic lav_word_t sat_word(input logic signed [SAT_W-1:0] v);
        lav_word_t r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX[WORD_W-1:0];
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAT_W-1:0] widen_prod(input logic signed [PROD_W-1:0] v);
        logic signed [SAT_W-1:0] w;
        w = v;
        return w;
    endfunction

    function automatic logic signed [SAT_W-1:0] widen_word(input lav_word_t v);
        logic signed [SAT_W-1:0] w;
        w = v;
        return w;
    endfunction

    // exact signed 32x32 product
    function automatic logic signed [PROD_W-1:0] mul_ss(input lav_word_t a, input lav_word_t b);
        logic signed [PROD_W-1:0] wa;
        logic signed [PROD_W-1:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // magnitude; the most negative word maps to 2^31
    function automatic logic [WORD_W-1:0] mag_word(input lav_word_t v);
        logic [WORD_W-1:0] m;
        m = v[WORD_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

// ===== hw/rtl/lav_if.sv =====
// Stream interfaces of the look-at view matrix block: camera items in, elements out.
// Depends on lav_pkg.
interface lav_cam_if;
    import lav_pkg::*;
    logic     valid;
    logic     ready;
    lav_cam_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lav_elem_if;
    import lav_pkg::*;
    logic      valid;
    logic      ready;
    lav_elem_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lav_norm.sv =====
// Pipelined vector normalizer: squares, sum, 32-step root, restoring divide per lane.
// Depends on lav_pkg. Side data rides along unchanged.
module lav_norm #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = lav_pkg::VEC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  lav_pkg::lav_vec_t in_vec,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output lav_pkg::lav_vec_t out_vec,
    output logic [SIDE_W-1:0] out_side
);
    import lav_pkg::*;

    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int QW        = DIV_STEPS;
    localparam int S_SUM     = 1;
    localparam int S_DIV0    = 2 + SQRT_STEPS;
    localparam int S_OUT     = S_DIV0 + DIV_STEPS;
    localparam int NS        = S_OUT + 1;
    localparam int TOP_BIT   = 2 * SQRT_STEPS - 2;
    // length 0.0001 squared, in Q(2F)
    localparam logic [PROD_W-1:0] NEAR_ZERO = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

    logic [NS-1:0]     vld_reg;
    lav_vec_t          vec_reg  [0:S_OUT-1];
    logic [SIDE_W-1:0] side_reg [0:S_OUT-1];
    logic              big_reg  [S_SUM:S_OUT-1];
    logic [PROD_W-1:0] sq_reg   [0:2];
    logic [PROD_W-1:0] rx_reg   [0:SQRT_STEPS];
    logic [PROD_W-1:0] rr_reg   [0:SQRT_STEPS];
    logic [WORD_W-1:0] len_reg  [0:DIV_STEPS-1];
    logic [WORD_W-1:0] rem_reg  [0:DIV_STEPS-1][0:2];
    logic [QW-1:0]     quo_reg  [0:DIV_STEPS-1][0:2];
    lav_vec_t          out_vec_reg;
    logic [SIDE_W-1:0] out_side_reg;

    logic [PROD_W-1:0] sq_next  [0:2];
    logic [PROD_W-1:0] sum_next;
    logic              big_next;
    logic [PROD_W-1:0] root_bit [0:SQRT_STEPS-1];
    logic [PROD_W-1:0] trial    [0:SQRT_STEPS-1];
    logic [WORD_W:0]   div_in   [0:DIV_STEPS-1][0:2];
    logic [WORD_W-1:0] div_len  [0:DIV_STEPS-1];
    logic              div_ge   [0:DIV_STEPS-1][0:2];
    lav_vec_t          out_vec_next;

    // squares of the magnitudes and their sum
    always_comb
    begin
        logic [PROD_W-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m = {{(PROD_W-WORD_W){1'b0}}, mag_word(in_vec[i])};
            sq_next[i] = m * m;
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        big_next = sum_next > NEAR_ZERO;
    end

    // integer square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            root_bit[k] = {{(PROD_W-1){1'b0}}, 1'b1} << (TOP_BIT - 2 * k);
            trial[k]    = rr_reg[k] + root_bit[k];
        end
    end

    // restoring divide of |c| * 2^F by the length, one quotient bit per stage
    always_comb
    begin
        div_len[0] = rr_reg[SQRT_STEPS][WORD_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            div_in[0][i] = {1'b0, mag_word(vec_reg[S_DIV0-1][i])};
        end
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            div_len[j] = len_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                div_in[j][i] = {rem_reg[j-1][i], 1'b0};
            end
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                div_ge[j][i] = div_in[j][i] >= {1'b0, div_len[j]};
            end
        end
    end

    // signed result, or the vector as it was when too short
    always_comb
    begin
        lav_word_t q;
        for (int i = 0; i < 3; i++)
        begin
            q = {{(WORD_W-QW){1'b0}}, quo_reg[DIV_STEPS-1][i]};
            if (!big_reg[S_OUT-1])
            begin
                out_vec_next[i] = vec_reg[S_OUT-1][i];
            end
            else if (vec_reg[S_OUT-1][i][WORD_W-1])
            begin
                out_vec_next[i] = -q;
            end
            else
            begin
                out_vec_next[i] = q;
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg[0]  <= in_vec;
            side_reg[0] <= in_side;
            for (int s = 1; s < S_OUT; s++)
            begin
                vec_reg[s]  <= vec_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            rx_reg[0]      <= sum_next;
            rr_reg[0]      <= '0;
            big_reg[S_SUM] <= big_next;
            for (int s = S_SUM + 1; s < S_OUT; s++)
            begin
                big_reg[s] <= big_reg[s-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                if (rx_reg[k] >= trial[k])
                begin
                    rx_reg[k+1] <= rx_reg[k] - trial[k];
                    rr_reg[k+1] <= (rr_reg[k] >> 1) + root_bit[k];
                end
                else
                begin
                    rx_reg[k+1] <= rx_reg[k];
                    rr_reg[k+1] <= rr_reg[k] >> 1;
                end
            end
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                len_reg[j] <= div_len[j];
                for (int i = 0; i < 3; i++)
                begin
                    if (div_ge[j][i])
                    begin
                        rem_reg[j][i] <= WORD_W'(div_in[j][i] - {1'b0, div_len[j]});
                    end
                    else
                    begin
                        rem_reg[j][i] <= div_in[j][i][WORD_W-1:0];
                    end
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                quo_reg[0][i] <= {{(QW-1){1'b0}}, div_ge[0][i]};
            end
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    quo_reg[j][i] <= {quo_reg[j-1][i][QW-2:0], div_ge[j][i]};
                end
            end
            out_vec_reg  <= out_vec_next;
            out_side_reg <= side_reg[S_OUT-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

// ===== hw/rtl/lav_serial.sv =====
// Output serializer: holds one finished matrix and sends its 16 entries in index order.
// Depends on lav_pkg and lav_elem_if.
module lav_serial #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lav_pkg::lav_mat_t in_mat,
    output logic              take,
    lav_elem_if.source        matrix
);
    import lav_pkg::*;

    localparam logic [1:0] ROW_S = 2'd0;
    localparam logic [1:0] ROW_U = 2'd1;
    localparam logic [1:0] ROW_F = 2'd2;
    localparam logic [1:0] ROW_W = 2'd3;
    localparam logic [1:0] COL_T = 2'd3;
    localparam lav_word_t  ONE   = lav_word_t'(64'd1 << FRAC_BITS);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    lav_mat_t         mat_reg;
    logic             load;
    logic             done;
    logic [1:0]       col;
    logic [1:0]       row;
    lav_word_t        value;

    // a new matrix may land as the last entry of the old one leaves
    assign done = busy_reg && matrix.ready && (idx_reg == LAST_IDX);
    assign take = !busy_reg || done;
    assign load = in_valid && take;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && matrix.ready)
        begin
            idx_next = idx_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg <= in_mat;
        end
    end

    // entry select, column-major
    assign col = idx_reg[3:2];
    assign row = idx_reg[1:0];

    always_comb
    begin
        value = '0;
        if (col == COL_T)
        begin
            unique case (row)
                ROW_S: value = mat_reg.tx;
                ROW_U: value = mat_reg.ty;
                ROW_F: value = mat_reg.tz;
                ROW_W: value = ONE;
            endcase
        end
        else
        begin
            unique case (row)
                ROW_S: value = mat_reg.s[col];
                ROW_U: value = mat_reg.u[col];
                ROW_F: value = mat_reg.nf[col];
                ROW_W: value = '0;
            endcase
        end
    end

    assign matrix.valid              = busy_reg;
    assign matrix.data.element_index = idx_reg;
    assign matrix.data.element_value = value;
    assign matrix.data.last_element  = (idx_reg == LAST_IDX);

endmodule

// ===== hw/rtl/lookat_view_matrix_top.sv =====
// Look-at view matrix top level: config registers, cross/dot stages, two normalizers.
// Depends on lav_pkg, lav_if, lav_norm, lav_serial and assert_macros.svh.
//
//  channel   dir  handshake      payload
//  camera    in   valid/ready    eye_x..z, target_x..z (Q16.16)
//  matrix    out  valid/ready    element_index, element_value, last_element
//  cfg       in   cfg_we         cfg_index, cfg_data (up_x, up_y, up_z)
//
// One entry leaves per cycle while matrix.ready is high; items enter back to back
// into the pipeline while it advances. A camera item passes stage 0, the forward
// normalizer, stages 1 and 2, the side normalizer and stages 3 to 6 before the
// serializer sends its first entry. Reset clears valid bits and sets up to (0, 1.0, 0).
// A stalled output freezes the whole pipeline once the handoff stage is full.
`include "assert_macros.svh"

module lookat_view_matrix_top #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lav_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lav_pkg::WORD_W-1:0]     cfg_data,
    lav_cam_if.sink                        camera,
    lav_elem_if.source                     matrix
);
    import lav_pkg::*;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};
    localparam lav_word_t UP_Y_RST = lav_word_t'(64'd1 << FRAC_BITS);

    lav_word_t up_x_reg;
    lav_word_t up_y_reg;
    lav_word_t up_z_reg;
    lav_vec_t  up;

    logic adv;
    logic take;

    logic     t0_valid_reg;
    lav_vec_t t0_eye_reg;
    lav_vec_t t0_f_reg;
    lav_vec_t t0_f_next;
    lav_vec_t cam_eye;
    lav_vec_t cam_tgt;

    logic     n1_valid;
    lav_vec_t n1_f;
    lav_vec_t n1_eye;

    logic                     t1_valid_reg;
    logic signed [PROD_W-1:0] t1_p_reg [0:5];
    logic signed [PROD_W-1:0] t1_p_next [0:5];
    lav_vec_t                 t1_f_reg;
    lav_vec_t                 t1_eye_reg;

    logic     t2_valid_reg;
    lav_vec_t t2_s_reg;
    lav_vec_t t2_s_next;
    lav_vec_t t2_f_reg;
    lav_vec_t t2_eye_reg;

    logic                 n2_valid;
    lav_vec_t             n2_s;
    logic [2*VEC_W-1:0]   n2_side;
    lav_vec_t             n2_f;
    lav_vec_t             n2_eye;

    logic                     t3_valid_reg;
    logic signed [PROD_W-1:0] t3_p_reg  [0:5];
    logic signed [PROD_W-1:0] t3_se_reg [0:2];
    logic signed [PROD_W-1:0] t3_fe_reg [0:2];
    logic signed [PROD_W-1:0] t3_p_next  [0:5];
    logic signed [PROD_W-1:0] t3_se_next [0:2];
    logic signed [PROD_W-1:0] t3_fe_next [0:2];
    lav_vec_t                 t3_s_reg;
    lav_vec_t                 t3_f_reg;
    lav_vec_t                 t3_eye_reg;

    logic      t4_valid_reg;
    lav_vec_t  t4_s_reg;
    lav_vec_t  t4_u_reg;
    lav_vec_t  t4_nf_reg;
    lav_vec_t  t4_eye_reg;
    lav_word_t t4_tx_reg;
    lav_word_t t4_tz_reg;
    lav_vec_t  t4_u_next;
    lav_vec_t  t4_nf_next;
    lav_word_t t4_tx_next;
    lav_word_t t4_tz_next;

    logic                     t5_valid_reg;
    logic signed [PROD_W-1:0] t5_ue_reg [0:2];
    lav_vec_t                 t5_s_reg;
    lav_vec_t                 t5_u_reg;
    lav_vec_t                 t5_nf_reg;
    lav_word_t                t5_tx_reg;
    lav_word_t                t5_tz_reg;

    logic      t6_valid_reg;
    lav_mat_t  t6_mat_reg;
    lav_word_t t6_ty_next;

    logic             out_vld;
    logic             mid_xfer;
    logic             last_xfer;
    logic             stalled;
    logic [IDX_W-1:0] out_idx;
    logic [IDX_W-1:0] next_idx;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= UP_Y_RST;
            up_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UP_X: up_x_reg <= cfg_data;
                REG_UP_Y: up_y_reg <= cfg_data;
                REG_UP_Z: up_z_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign up = {up_z_reg, up_y_reg, up_x_reg};

    // whole pipeline moves unless the handoff stage is full and blocked
    assign adv          = !t6_valid_reg || take;
    assign camera.ready = adv;

    assign cam_eye = {camera.data.eye_z, camera.data.eye_y, camera.data.eye_x};
    assign cam_tgt = {camera.data.target_z, camera.data.target_y, camera.data.target_x};

    // stage 0: forward = target - eye, saturated
    always_comb
    begin
        logic signed [WORD_W:0] diff;
        logic signed [SAT_W-1:0] wide;
        for (int i = 0; i < 3; i++)
        begin
            diff = {cam_tgt[i][WORD_W-1], cam_tgt[i]} - {cam_eye[i][WORD_W-1], cam_eye[i]};
            wide = diff;
            t0_f_next[i] = sat_word(wide);
        end
    end

    // stage 1: products of f x up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1_p_next[2*i]   = mul_ss(n1_f[NXT[i]], up[PRV[i]]);
            t1_p_next[2*i+1] = mul_ss(n1_f[PRV[i]], up[NXT[i]]);
        end
    end

    // stage 2: side vector before normalizing
    always_comb
    begin
        logic signed [SAT_W-1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d = widen_prod(t1_p_reg[2*i]) - widen_prod(t1_p_reg[2*i+1]);
            t2_s_next[i] = sat_word(d >>> FRAC_BITS);
        end
    end

    assign n2_f   = n2_side[2*VEC_W-1:VEC_W];
    assign n2_eye = n2_side[VEC_W-1:0];

    // stage 3: products of s x f, s.eye and f.eye
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t3_p_next[2*i]   = mul_ss(n2_s[NXT[i]], n2_f[PRV[i]]);
            t3_p_next[2*i+1] = mul_ss(n2_s[PRV[i]], n2_f[NXT[i]]);
            t3_se_next[i]    = mul_ss(n2_s[i], n2_eye[i]);
            t3_fe_next[i]    = mul_ss(n2_f[i], n2_eye[i]);
        end
    end

    // stage 4: true up, negated forward, two translation terms
    always_comb
    begin
        logic signed [SAT_W-1:0] d;
        logic signed [SAT_W-1:0] acc_s;
        logic signed [SAT_W-1:0] acc_f;
        for (int i = 0; i < 3; i++)
        begin
            d = widen_prod(t3_p_reg[2*i]) - widen_prod(t3_p_reg[2*i+1]);
            t4_u_next[i]  = sat_word(d >>> FRAC_BITS);
            t4_nf_next[i] = sat_word(-widen_word(t3_f_reg[i]));
        end
        acc_s = widen_prod(t3_se_reg[0]) + widen_prod(t3_se_reg[1]) + widen_prod(t3_se_reg[2]);
        acc_f = widen_prod(t3_fe_reg[0]) + widen_prod(t3_fe_reg[1]) + widen_prod(t3_fe_reg[2]);
        t4_tx_next = sat_word(-(acc_s >>> FRAC_BITS));
        t4_tz_next = sat_word(acc_f >>> FRAC_BITS);
    end

    // stage 6: last translation term
    always_comb
    begin
        logic signed [SAT_W-1:0] acc_u;
        acc_u = widen_prod(t5_ue_reg[0]) + widen_prod(t5_ue_reg[1]) + widen_prod(t5_ue_reg[2]);
        t6_ty_next = sat_word(-(acc_u >>> FRAC_BITS));
    end

    // valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_valid_reg <= camera.valid;
            t1_valid_reg <= n1_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= n2_valid;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= t4_valid_reg;
            t6_valid_reg <= t5_valid_reg;
        end
    end

    // payload of the top-level stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_eye_reg <= cam_eye;
            t0_f_reg   <= t0_f_next;

            for (int k = 0; k < 6; k++)
            begin
                t1_p_reg[k] <= t1_p_next[k];
                t3_p_reg[k] <= t3_p_next[k];
            end
            t1_f_reg   <= n1_f;
            t1_eye_reg <= n1_eye;

            t2_s_reg   <= t2_s_next;
            t2_f_reg   <= t1_f_reg;
            t2_eye_reg <= t1_eye_reg;

            for (int i = 0; i < 3; i++)
            begin
                t3_se_reg[i] <= t3_se_next[i];
                t3_fe_reg[i] <= t3_fe_next[i];
                t5_ue_reg[i] <= mul_ss(t4_u_reg[i], t4_eye_reg[i]);
            end
            t3_s_reg   <= n2_s;
            t3_f_reg   <= n2_f;
            t3_eye_reg <= n2_eye;

            t4_s_reg   <= t3_s_reg;
            t4_u_reg   <= t4_u_next;
            t4_nf_reg  <= t4_nf_next;
            t4_eye_reg <= t3_eye_reg;
            t4_tx_reg  <= t4_tx_next;
            t4_tz_reg  <= t4_tz_next;

            t5_s_reg  <= t4_s_reg;
            t5_u_reg  <= t4_u_reg;
            t5_nf_reg <= t4_nf_reg;
            t5_tx_reg <= t4_tx_reg;
            t5_tz_reg <= t4_tz_reg;

            t6_mat_reg.s  <= t5_s_reg;
            t6_mat_reg.u  <= t5_u_reg;
            t6_mat_reg.nf <= t5_nf_reg;
            t6_mat_reg.tx <= t5_tx_reg;
            t6_mat_reg.ty <= t6_ty_next;
            t6_mat_reg.tz <= t5_tz_reg;
        end
    end

    // normalize forward
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (VEC_W)
    ) u_norm_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t0_valid_reg),
        .in_vec    (t0_f_reg),
        .in_side   (t0_eye_reg),
        .out_valid (n1_valid),
        .out_vec   (n1_f),
        .out_side  (n1_eye)
    );

    // normalize side
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (2 * VEC_W)
    ) u_norm_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t2_valid_reg),
        .in_vec    (t2_s_reg),
        .in_side   ({t2_f_reg, t2_eye_reg}),
        .out_valid (n2_valid),
        .out_vec   (n2_s),
        .out_side  (n2_side)
    );

    lav_serial #(
        .FRAC_BITS (FRAC_BITS)
    ) u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (t6_valid_reg),
        .in_mat   (t6_mat_reg),
        .take     (take),
        .matrix   (matrix)
    );

    // terms used by the checks
    assign out_vld   = matrix.valid;
    assign out_idx   = matrix.data.element_index;
    assign next_idx  = out_idx + 4'd1;
    assign mid_xfer  = matrix.valid && matrix.ready && !matrix.data.last_element;
    assign last_xfer = matrix.valid && matrix.ready && matrix.data.last_element;
    assign stalled   = t6_valid_reg && !adv;

    // checks
    `LAV_ASSERT_NXT(a_idx_step, mid_xfer, out_vld && out_idx == $past(next_idx), "index skipped")
    `LAV_ASSERT_NXT(a_run_start, last_xfer, !out_vld || out_idx == '0, "restart not at zero")
    `LAV_ASSERT_NXT(a_stall_hold, stalled, t6_valid_reg && $stable(t6_mat_reg), "handoff moved")
    `LAV_ASSERT_IMP(a_ready_stall, !camera.ready, stalled && out_vld, "ready low, no output")

endmodule

// ===== tb/tb_lookat_view_matrix_top.sv =====
// Self-checking testbench for lookat_view_matrix_top: directed and random cameras.
// Depends on lav_pkg, lav_if and the RTL top; builds its own exact-width
// view matrix predictor.
module tb_lookat_view_matrix_top;
    import lav_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 2 * FRAC + 120;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    lav_cam_if  camera_if ();
    lav_elem_if matrix_if ();

    lookat_view_matrix_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .camera    (camera_if),
        .matrix    (matrix_if)
    );

    // predictor copy of the up registers
    lav_word_t world_up [3];
    lav_elem_t expected_elems [$];
    int        fail_count;
    int        cycle_count;
    int        src_idle_pct;
    int        snk_idle_pct;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------- view matrix predictor ----------------
    function automatic wide_t clamp_word(wide_t v);
        if (v > wide_t'(32'sh7fffffff))
        begin
            return wide_t'(32'sh7fffffff);
        end
        if (v < -(wide_t'(1) <<< 31))
        begin
            return -(wide_t'(1) <<< 31);
        end
        return v;
    endfunction

    function automatic wide_t floor_sqrt(wide_t x);
        wide_t res;
        wide_t bit_w;
        res = 0;
        bit_w = wide_t'(1) <<< 124;
        while (bit_w > x)
        begin
            bit_w = bit_w >>> 2;
        end
        while (bit_w != 0)
        begin
            if (x >= res + bit_w)
            begin
                x = x - (res + bit_w);
                res = (res >>> 1) + bit_w;
            end
            else
            begin
                res = res >>> 1;
            end
            bit_w = bit_w >>> 2;
        end
        return res;
    endfunction

    // scale to unit length unless the vector is within 0.0001 of zero
    function automatic vec3_t unit_vec(vec3_t v);
        wide_t q;
        wide_t len;
        vec3_t r;
        q = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        r = v;
        if (q > ((wide_t'(1) <<< (2 * FRAC)) / 100000000))
        begin
            len = floor_sqrt(q);
            for (int i = 0; i < 3; i++)
            begin
                r[i] = (v[i] <<< FRAC) / len;
            end
        end
        return r;
    endfunction

    function automatic vec3_t cross_vec(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = clamp_word((a[1] * b[2] - a[2] * b[1]) >>> FRAC);
        o[1] = clamp_word((a[2] * b[0] - a[0] * b[2]) >>> FRAC);
        o[2] = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> FRAC);
        return o;
    endfunction

    function automatic wide_t dot_vec(vec3_t a, vec3_t b);
        return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC;
    endfunction

    function automatic void predict_matrix(lav_cam_t c);
        vec3_t eye;
        vec3_t fwd;
        vec3_t side;
        vec3_t upt;
        vec3_t upw;
        wide_t m [16];
        lav_elem_t el;
        eye[0] = wide_t'(c.eye_x);
        eye[1] = wide_t'(c.eye_y);
        eye[2] = wide_t'(c.eye_z);
        fwd[0] = clamp_word(wide_t'(c.target_x) - eye[0]);
        fwd[1] = clamp_word(wide_t'(c.target_y) - eye[1]);
        fwd[2] = clamp_word(wide_t'(c.target_z) - eye[2]);
        for (int i = 0; i < 3; i++)
        begin
            upw[i] = wide_t'(world_up[i]);
        end
        fwd  = unit_vec(fwd);
        side = unit_vec(cross_vec(fwd, upw));
        upt  = cross_vec(side, fwd);
        for (int i = 0; i < 3; i++)
        begin
            m[4 * i]     = side[i];
            m[4 * i + 1] = upt[i];
            m[4 * i + 2] = -fwd[i];
            m[4 * i + 3] = 0;
        end
        m[12] = -dot_vec(side, eye);
        m[13] = -dot_vec(upt, eye);
        m[14] = dot_vec(fwd, eye);
        m[15] = wide_t'(1) <<< FRAC;
        for (int i = 0; i < 16; i++)
        begin
            el.element_index = IDX_W'(i);
            el.element_value = lav_word_t'(clamp_word(m[i]));
            el.last_element  = (IDX_W'(i) == LAST_IDX);
            expected_elems = {expected_elems, el};
        end
    endfunction

    // ---------------- drivers ----------------
    task automatic send_camera(lav_cam_t c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            camera_if.valid = 1'b0;
            @(negedge clk);
        end
        camera_if.valid = 1'b1;
        camera_if.data  = c;
        do
        begin
            @(posedge clk);
        end
        while (!camera_if.ready);
        predict_matrix(c);
    endtask

    // register write once the pipeline has drained
    task automatic write_up(logic [CFG_IDX_W-1:0] idx, lav_word_t val);
        @(negedge clk);
        camera_if.valid = 1'b0;
        wait (expected_elems.size() == 0);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_UP_X: world_up[0] = val;
            REG_UP_Y: world_up[1] = val;
            REG_UP_Z: world_up[2] = val;
            default: ;
        endcase
    endtask

    function automatic lav_cam_t cam(int ex, int ey, int ez, int tx, int ty, int tz);
        lav_cam_t c;
        c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
        c.target_x = tx; c.target_y = ty; c.target_z = tz;
        return c;
    endfunction

    function automatic lav_word_t rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            // within +-64.0
            return lav_word_t'(int'($urandom_range(23'h7fffff)) - 32'sh400000);
        end
        return lav_word_t'($urandom);
    endfunction

    function automatic lav_cam_t rand_camera();
        lav_cam_t c;
        c.eye_x = rand_coord(); c.eye_y = rand_coord(); c.eye_z = rand_coord();
        if ($urandom_range(99) < 15)
        begin
            // target within a few LSBs of the eye: short forward vector
            c.target_x = c.eye_x + lav_word_t'(int'($urandom_range(16)) - 8);
            c.target_y = c.eye_y + lav_word_t'(int'($urandom_range(16)) - 8);
            c.target_z = c.eye_z + lav_word_t'(int'($urandom_range(16)) - 8);
        end
        else
        begin
            c.target_x = rand_coord(); c.target_y = rand_coord(); c.target_z = rand_coord();
        end
        return c;
    endfunction

    // ---------------- sink side ----------------
    always @(negedge clk)
    begin
        matrix_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // compare each transfer with the oldest expected entry
    always @(posedge clk)
    begin
        lav_elem_t exp_el;
        if (rst_n && matrix_if.valid && matrix_if.ready)
        begin
            if (expected_elems.size() == 0)
            begin
                $error("unexpected element index %0d", matrix_if.data.element_index);
                fail_count++;
            end
            else
            begin
                exp_el = expected_elems.pop_front();
                if (matrix_if.data.element_index !== exp_el.element_index)
                begin
                    $error("element_index expected %0d actual %0d",
                        exp_el.element_index, matrix_if.data.element_index);
                    fail_count++;
                end
                if (matrix_if.data.element_value !== exp_el.element_value)
                begin
                    $error("element_value expected %0d actual %0d",
                        exp_el.element_value, matrix_if.data.element_value);
                    fail_count++;
                end
                if (matrix_if.data.last_element !== exp_el.last_element)
                begin
                    $error("last_element expected %0b actual %0b",
                        exp_el.last_element, matrix_if.data.last_element);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lookat_view_matrix_top: mismatch");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed_cameras();
        send_camera(cam(0, 0, 0, 0, 0, 0));                   // zero forward
        send_camera(cam(100, 200, 300, 106, 200, 300));       // length just below the 0.0001 limit
        send_camera(cam(100, 200, 300, 107, 200, 300));       // just above the limit
        send_camera(cam(0, 0, 0, 0, 32'sh50000, 0));          // forward along up
        send_camera(cam(0, 32'sh30000, 0, 0, -32'sh20000, 0)); // forward against up
        send_camera(cam(0, 0, 32'sh50000, 0, 0, 0));
        send_camera(cam(32'sh30000, 32'sh20000, 32'sh10000, -32'sh10000, 32'sh8000,
            32'sh20000));
        send_camera(cam(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));   // saturated difference
        send_camera(cam(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_camera(cam(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
        send_camera(cam(32'sh80000000, 0, 32'sh7fffffff, 0, -1, 32'sh7ffffffe));
    endtask

    task automatic test_up_extremes();
        write_up(REG_UP_X, 32'sh7fffffff);
        write_up(REG_UP_Y, 32'sh80000000);
        write_up(REG_UP_Z, 32'sh7fffffff);
        send_camera(cam(32'sh10000, 0, 0, 0, 32'sh10000, 32'sh20000));
        send_camera(cam(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 0, 32'sh80000000));
        write_up(REG_UP_X, 0);
        write_up(REG_UP_Y, 0);
        write_up(REG_UP_Z, 0);
        send_camera(cam(0, 0, 32'sh50000, 0, 0, 0));           // zero up: short side
        // index beyond the register file must be ignored
        write_up(REG_UNUSED, 32'sh12345678);
        write_up(REG_UP_Y, 32'sh10000);
        send_camera(cam(0, 32'sh10000, 32'sh50000, 32'sh10000, 0, 0));
    endtask

    task automatic test_random_cameras(int n, int src_pct, int snk_pct);
        write_up(REG_UP_X, ($urandom_range(1)) ? lav_word_t'($urandom) : 0);
        write_up(REG_UP_Y, ($urandom_range(1)) ? lav_word_t'($urandom) : 32'sh10000);
        write_up(REG_UP_Z, lav_word_t'(int'($urandom_range(32'h3ffff)) - 32'sh20000));
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (n)
        begin
            send_camera(rand_camera());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        camera_if.valid = 1'b0;
        camera_if.data = '0;
        matrix_if.ready = 1'b0;
        world_up[0] = 0;
        world_up[1] = 32'sh10000;
        world_up[2] = 0;
        fail_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cameras();
        test_up_extremes();
        test_random_cameras(100, 11, 45);
        test_random_cameras(100, 45, 11);
        test_random_cameras(100, 0, 0);

        @(negedge clk);
        camera_if.valid = 1'b0;
        wait (expected_elems.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("lookat_view_matrix_top: match");
        end
        else
        begin
            $display("lookat_view_matrix_top: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lav_pkg.sv
hw/rtl/lav_if.sv
hw/rtl/lav_norm.sv
hw/rtl/lav_serial.sv
hw/rtl/lookat_view_matrix_top.sv
tb/tb_lookat_view_matrix_top.sv
